/* sv/glpx_pkg.sv */
`timescale 1ns / 1ps

package glpx_pkg;

    localparam int COORD_BITS = 11;
    localparam int CALC_BITS  = COORD_BITS + 2;
    localparam int GLYPH_COLS = 8;
    localparam int COL_BITS   = 4;
    localparam int OFF_BITS   = 5;
    localparam int Y_BIAS     = 9;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [CALC_BITS-1:0]  calc_t;

    typedef enum logic [2:0]
    {
        CFG_FONT_HEIGHT = 3'd0,
        CFG_SCALE       = 3'd1,
        CFG_CLIP_ENABLE = 3'd2,
        CFG_CLIP_LEFT   = 3'd3,
        CFG_CLIP_TOP    = 3'd4,
        CFG_CLIP_RIGHT  = 3'd5,
        CFG_CLIP_BOTTOM = 3'd6
    } cfg_idx_t;

    localparam logic [4:0] FONT_HEIGHT_RST = 5'd8;
    localparam logic [1:0] SCALE_RST       = 2'd1;
    localparam coord_t     CLIP_LEFT_RST   = 11'sd0;
    localparam coord_t     CLIP_TOP_RST    = 11'sd0;
    localparam coord_t     CLIP_RIGHT_RST  = 11'sd319;
    localparam coord_t     CLIP_BOTTOM_RST = 11'sd239;

    typedef struct packed
    {
        logic load;
        logic step;
        logic pend_load;
        logic out_load;
        logic out_last;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic hit;
        logic done;
    } dp_status_t;

endpackage

/* sv/glyph_row_pixel_expander_core.sv */
`timescale 1ns / 1ps
// The first pixel is held in the pending register during the scan, then moved to the output register.
// Rows are taken one at a time: item_stall stays high until the previous row's scan ends.
// The scan counter checks one candidate per cycle unless a held pixel waits on a stalled output.
// One pending pixel is held back so the final one can carry last_pixel.
// Reset (rst_n, async, active low) clears control and restores register defaults.
module glyph_row_pixel_expander_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [7:0]       row_bits,
    input  logic [3:0]       glyph_width,
    input  logic [3:0]       row_number,
    input  glpx_pkg::coord_t origin_x,
    input  glpx_pkg::coord_t origin_y,
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output glpx_pkg::coord_t pixel_x,
    output glpx_pkg::coord_t pixel_y,
    output logic             last_pixel,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [10:0]      cfg_data
);

    glpx_pkg::ctrl_cmd_t  cmd;
    glpx_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    glpx_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    glpx_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .row_bits    (row_bits),
        .glyph_width (glyph_width),
        .row_number  (row_number),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .cmd         (cmd),
        .sts         (sts),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (last_pixel)
    );

`ifndef SYNTHESIS
    a_one_row_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("row accepted while previous row still scanning");

    a_step_only_before_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !sts.done)
        else $error("scan advanced past row width");

    a_mid_emit_refills: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !cmd.out_last) |-> cmd.pend_load)
        else $error("non-final pixel emitted without refilling pending slot");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!pixel_valid || !pixel_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule

/* sv/glpx_datapath.sv */
`timescale 1ns / 1ps

module glpx_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [10:0]            cfg_data,
    input  logic [7:0]             row_bits,
    input  logic [3:0]             glyph_width,
    input  logic [3:0]             row_number,
    input  glpx_pkg::coord_t       origin_x,
    input  glpx_pkg::coord_t       origin_y,
    input  glpx_pkg::ctrl_cmd_t    cmd,
    output glpx_pkg::dp_status_t   sts,
    output glpx_pkg::coord_t       pixel_x,
    output glpx_pkg::coord_t       pixel_y,
    output logic                   last_pixel
);

    logic [4:0]       font_height_reg;
    logic [1:0]       scale_reg;
    logic             clip_enable_reg;
    glpx_pkg::coord_t clip_left_reg;
    glpx_pkg::coord_t clip_top_reg;
    glpx_pkg::coord_t clip_right_reg;
    glpx_pkg::coord_t clip_bottom_reg;

    logic [7:0]                         bits_reg;
    logic [glpx_pkg::COL_BITS-1:0]      width_reg;
    glpx_pkg::coord_t                   ox_reg;
    glpx_pkg::calc_t                    y0_reg;
    logic [glpx_pkg::COL_BITS-1:0]      col_reg;
    logic [glpx_pkg::COL_BITS-1:0]      col_next;
    logic                               i_reg;
    logic                               i_next;
    logic                               j_reg;
    logic                               j_next;

    glpx_pkg::coord_t pend_x_reg;
    glpx_pkg::coord_t pend_y_reg;
    glpx_pkg::coord_t out_x_reg;
    glpx_pkg::coord_t out_y_reg;
    logic             out_last_reg;

    logic                               s2;
    logic [glpx_pkg::OFF_BITS-1:0]      col_off;
    logic [glpx_pkg::OFF_BITS-1:0]      row_off;
    logic [glpx_pkg::COL_BITS-1:0]      width_sat;
    glpx_pkg::calc_t                    y0_calc;
    glpx_pkg::calc_t                    px;
    glpx_pkg::calc_t                    py;
    logic                               bit_set;
    logic                               in_window;

    assign s2 = scale_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_height_reg <= glpx_pkg::FONT_HEIGHT_RST;
            scale_reg       <= glpx_pkg::SCALE_RST;
            clip_enable_reg <= 1'b0;
            clip_left_reg   <= glpx_pkg::CLIP_LEFT_RST;
            clip_top_reg    <= glpx_pkg::CLIP_TOP_RST;
            clip_right_reg  <= glpx_pkg::CLIP_RIGHT_RST;
            clip_bottom_reg <= glpx_pkg::CLIP_BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                glpx_pkg::CFG_FONT_HEIGHT: font_height_reg <= cfg_data[4:0];
                glpx_pkg::CFG_SCALE:       scale_reg       <= cfg_data[1:0];
                glpx_pkg::CFG_CLIP_ENABLE: clip_enable_reg <= cfg_data[0];
                glpx_pkg::CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data;
                glpx_pkg::CFG_CLIP_TOP:    clip_top_reg    <= cfg_data;
                glpx_pkg::CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                glpx_pkg::CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign width_sat = (glyph_width > glpx_pkg::COL_BITS'(glpx_pkg::GLYPH_COLS))
                     ? glpx_pkg::COL_BITS'(glpx_pkg::GLYPH_COLS) : glyph_width;
    assign row_off   = s2 ? {row_number, 1'b0} : {1'b0, row_number};
    assign y0_calc   = glpx_pkg::calc_t'(origin_y) + glpx_pkg::calc_t'(row_off)
                     + glpx_pkg::calc_t'(glpx_pkg::Y_BIAS)
                     - glpx_pkg::calc_t'(font_height_reg);

    assign col_off   = s2 ? {col_reg, 1'b0} : {1'b0, col_reg};
    assign px        = glpx_pkg::calc_t'(ox_reg) + glpx_pkg::calc_t'(col_off)
                     + glpx_pkg::calc_t'(i_reg);
    assign py        = y0_reg + glpx_pkg::calc_t'(j_reg);
    assign bit_set   = bits_reg[3'd7 - col_reg[2:0]];
    assign in_window = (px >= glpx_pkg::calc_t'(clip_left_reg))
                    && (px <= glpx_pkg::calc_t'(clip_right_reg))
                    && (py >= glpx_pkg::calc_t'(clip_top_reg))
                    && (py <= glpx_pkg::calc_t'(clip_bottom_reg));

    assign sts.done = (col_reg >= width_reg);
    assign sts.hit  = !sts.done && bit_set && (!clip_enable_reg || in_window);

    always_comb
    begin
        col_next = col_reg + 1'b1;
        i_next   = 1'b0;
        j_next   = 1'b0;
        if (bit_set && s2)
        begin
            if (!j_reg)
            begin
                col_next = col_reg;
                i_next   = i_reg;
                j_next   = 1'b1;
            end
            else if (!i_reg)
            begin
                col_next = col_reg;
                i_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg  <= row_bits;
            width_reg <= width_sat;
            ox_reg    <= origin_x;
            y0_reg    <= y0_calc;
            col_reg   <= '0;
            i_reg     <= 1'b0;
            j_reg     <= 1'b0;
        end
        else if (cmd.step)
        begin
            col_reg <= col_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
        end
        if (cmd.out_load)
        begin
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_last_reg <= cmd.out_last;
        end
        if (cmd.pend_load)
        begin
            pend_x_reg <= px[glpx_pkg::COORD_BITS-1:0];
            pend_y_reg <= py[glpx_pkg::COORD_BITS-1:0];
        end
    end

    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;
    assign last_pixel = out_last_reg;

endmodule

/* sv/glpx_ctrl.sv */
`timescale 1ns / 1ps

module glpx_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    input  glpx_pkg::dp_status_t  sts,
    output glpx_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pend_valid_reg;
    logic   pend_valid_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !pixel_stall;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        pend_valid_next = pend_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.done)
                begin
                    if (!sts.hit)
                    begin
                        cmd.step = 1'b1;
                    end
                    else if (!pend_valid_reg)
                    begin
                        cmd.step        = 1'b1;
                        cmd.pend_load   = 1'b1;
                        pend_valid_next = 1'b1;
                    end
                    else if (out_free)
                    begin
                        cmd.step      = 1'b1;
                        cmd.pend_load = 1'b1;
                        cmd.out_load  = 1'b1;
                    end
                end
                else if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_last    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && pixel_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign item_stall  = (state_reg != ST_IDLE);
    assign pixel_valid = out_valid_reg;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_SCALE    = 2;
    localparam int DRAIN_CYCLES = 48;
    localparam int MAX_REPORTS  = 20;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct
    {
        glpx_pkg::coord_t x;
        glpx_pkg::coord_t y;
        logic             last;
    } pixel_t;

    typedef enum logic
    {
        ENT_ROW,
        ENT_CFG
    } ent_kind_t;

    typedef struct
    {
        ent_kind_t kind;
        int        idx;
        int        data;
        int        bits;
        int        width;
        int        rnum;
        int        ox;
        int        oy;
        bit        typed;
        int        ex;
        int        ey;
    } entry_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    logic [7:0]       row_bits = '0;
    logic [3:0]       glyph_width = '0;
    logic [3:0]       row_number = '0;
    glpx_pkg::coord_t origin_x = '0;
    glpx_pkg::coord_t origin_y = '0;
    logic             pixel_valid;
    logic             pixel_stall = 1'b0;
    glpx_pkg::coord_t pixel_x;
    glpx_pkg::coord_t pixel_y;
    logic             last_pixel;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [2:0]       cfg_index = '0;
    logic [10:0]      cfg_data = '0;

    logic [4:0]       cur_font_height = glpx_pkg::FONT_HEIGHT_RST;
    logic [1:0]       cur_scale = glpx_pkg::SCALE_RST;
    logic             cur_clip_en = 1'b0;
    glpx_pkg::coord_t cur_left = glpx_pkg::CLIP_LEFT_RST;
    glpx_pkg::coord_t cur_top = glpx_pkg::CLIP_TOP_RST;
    glpx_pkg::coord_t cur_right = glpx_pkg::CLIP_RIGHT_RST;
    glpx_pkg::coord_t cur_bottom = glpx_pkg::CLIP_BOTTOM_RST;

    pixel_t      expected_pixels[$];
    entry_t      directed_rows[$];
    pixel_t      want;
    int          errors = 0;
    int          rows_sent = 0;
    int          pixels_checked = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    glyph_row_pixel_expander_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .row_bits    (row_bits),
        .glyph_width (glyph_width),
        .row_number  (row_number),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void expand_row(logic [7:0] bits, logic [3:0] width,
                                       logic [3:0] rnum, glpx_pkg::coord_t ox,
                                       glpx_pkg::coord_t oy);
        int     s;
        int     w;
        int     y0;
        int     px;
        int     py;
        int     n;
        pixel_t p;
        s = (cur_scale == 0) ? 1 : ((cur_scale > MAX_SCALE) ? MAX_SCALE : int'(cur_scale));
        w = (width > glpx_pkg::GLYPH_COLS) ? glpx_pkg::GLYPH_COLS : int'(width);
        y0 = int'(oy) + int'(rnum) * s + glpx_pkg::Y_BIAS - int'(cur_font_height);
        n = 0;
        for (int col = 0; col < w; col++)
        begin
            if (bits[7 - col])
            begin
                for (int i = 0; i < s; i++)
                begin
                    for (int j = 0; j < s; j++)
                    begin
                        px = int'(ox) + col * s + i;
                        py = y0 + j;
                        if (!cur_clip_en || (px >= int'(cur_left) && px <= int'(cur_right) &&
                                             py >= int'(cur_top) && py <= int'(cur_bottom)))
                        begin
                            p.x = glpx_pkg::coord_t'(px);
                            p.y = glpx_pkg::coord_t'(py);
                            p.last = 1'b0;
                            expected_pixels.push_back(p);
                            n++;
                        end
                    end
                end
            end
        end
        if (n > 0)
            expected_pixels[expected_pixels.size() - 1].last = 1'b1;
    endfunction

    task automatic send_row(input int bits, input int width, input int rnum,
                            input int ox, input int oy, input bit typed,
                            input int ex, input int ey);
        pixel_t p;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        row_bits    <= bits[7:0];
        glyph_width <= width[3:0];
        row_number  <= rnum[3:0];
        origin_x    <= ox[10:0];
        origin_y    <= oy[10:0];
        do @(posedge clk); while (item_stall);
        if (typed)
        begin
            p.x = glpx_pkg::coord_t'(ex);
            p.y = glpx_pkg::coord_t'(ey);
            p.last = 1'b1;
            expected_pixels.push_back(p);
        end
        else
        begin
            expand_row(bits[7:0], width[3:0], rnum[3:0], glpx_pkg::coord_t'(ox),
                       glpx_pkg::coord_t'(oy));
        end
        rows_sent++;
    endtask

    task automatic stop_items();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input int data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_data  <= data[10:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx[2:0])
            glpx_pkg::CFG_FONT_HEIGHT: cur_font_height = data[4:0];
            glpx_pkg::CFG_SCALE:       cur_scale = data[1:0];
            glpx_pkg::CFG_CLIP_ENABLE: cur_clip_en = data[0];
            glpx_pkg::CFG_CLIP_LEFT:   cur_left = data[10:0];
            glpx_pkg::CFG_CLIP_TOP:    cur_top = data[10:0];
            glpx_pkg::CFG_CLIP_RIGHT:  cur_right = data[10:0];
            glpx_pkg::CFG_CLIP_BOTTOM: cur_bottom = data[10:0];
            default: ;
        endcase
    endtask

    task automatic close_cfg();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        int left;
        int top;
        left = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(120) - 40;
        top  = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(120) - 40;
        write_reg(glpx_pkg::CFG_FONT_HEIGHT,
                  ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(16, 1));
        write_reg(glpx_pkg::CFG_SCALE, $urandom_range(2047));
        write_reg(glpx_pkg::CFG_CLIP_ENABLE, $urandom_range(2047));
        write_reg(glpx_pkg::CFG_CLIP_LEFT, left);
        write_reg(glpx_pkg::CFG_CLIP_TOP, top);
        write_reg(glpx_pkg::CFG_CLIP_RIGHT,
                  ($urandom_range(3) == 0) ? $urandom_range(2047) : left + $urandom_range(300));
        write_reg(glpx_pkg::CFG_CLIP_BOTTOM,
                  ($urandom_range(3) == 0) ? $urandom_range(2047) : top + $urandom_range(240));
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, $urandom_range(2047));
        close_cfg();
    endtask

    task automatic send_random_row();
        int width;
        int ox;
        int oy;
        width = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
        ox = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(360) - 30;
        oy = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(280) - 30;
        send_row($urandom_range(255), width, $urandom_range(15), ox, oy, 1'b0, 0, 0);
    endtask

    function automatic void add_row(int bits, int width, int rnum, int ox, int oy);
        entry_t e;
        e = '{ENT_ROW, 0, 0, bits, width, rnum, ox, oy, 1'b0, 0, 0};
        directed_rows.push_back(e);
    endfunction

    function automatic void add_typed(int bits, int width, int rnum, int ox, int oy,
                                      int ex, int ey);
        entry_t e;
        e = '{ENT_ROW, 0, 0, bits, width, rnum, ox, oy, 1'b1, ex, ey};
        directed_rows.push_back(e);
    endfunction

    function automatic void add_cfg(int idx, int data);
        entry_t e;
        e = '{ENT_CFG, idx, data, 0, 0, 0, 0, 0, 1'b0, 0, 0};
        directed_rows.push_back(e);
    endfunction

    function automatic void build_directed();
        add_typed(8'h80, 1, 0, 5, 10, 5, 11);
        add_typed(8'h01, 8, 0, 0, 0, 7, 1);
        add_row(8'h00, 8, 0, 0, 0);
        add_row(8'hFF, 0, 3, 0, 0);
        add_row(8'hFF, 8, 15, 1023, 1023);
        add_row(8'hFF, 15, 0, -1024, -1024);
        add_row(8'hAA, 5, 7, 100, 50);
        add_cfg(glpx_pkg::CFG_SCALE, 2);
        add_row(8'hFF, 8, 15, 1016, 1000);
        add_row(8'h81, 8, 3, -20, -5);
        add_cfg(glpx_pkg::CFG_SCALE, 3);
        add_row(8'hC0, 2, 1, -1024, -1024);
        add_cfg(glpx_pkg::CFG_SCALE, 0);
        add_typed(8'h80, 1, 2, 10, 20, 10, 23);
        add_cfg(glpx_pkg::CFG_SCALE, 1);
        add_cfg(glpx_pkg::CFG_FONT_HEIGHT, 0);
        add_typed(8'h80, 1, 0, 0, 0, 0, 9);
        add_cfg(glpx_pkg::CFG_FONT_HEIGHT, 31);
        add_typed(8'h80, 1, 0, 0, 0, 0, -22);
        add_row(8'hC3, 8, 5, 300, 200);
        add_cfg(glpx_pkg::CFG_FONT_HEIGHT, 16);
        add_cfg(glpx_pkg::CFG_CLIP_ENABLE, 1);
        add_cfg(glpx_pkg::CFG_SCALE, 2);
        add_row(8'hFF, 8, 0, -3, 8);
        add_row(8'hFF, 8, 0, 315, 245);
        add_cfg(glpx_pkg::CFG_CLIP_LEFT, 100);
        add_cfg(glpx_pkg::CFG_CLIP_RIGHT, 100);
        add_cfg(glpx_pkg::CFG_CLIP_TOP, 50);
        add_cfg(glpx_pkg::CFG_CLIP_BOTTOM, 50);
        add_row(8'hFF, 8, 0, 95, 57);
        add_cfg(glpx_pkg::CFG_CLIP_LEFT, 10);
        add_cfg(glpx_pkg::CFG_CLIP_RIGHT, 5);
        add_row(8'hFF, 8, 0, 0, 57);
        add_cfg(glpx_pkg::CFG_CLIP_LEFT, -1024);
        add_cfg(glpx_pkg::CFG_CLIP_TOP, -1024);
        add_cfg(glpx_pkg::CFG_CLIP_RIGHT, 1023);
        add_cfg(glpx_pkg::CFG_CLIP_BOTTOM, 1023);
        add_cfg(glpx_pkg::CFG_SCALE, 1);
        add_cfg(glpx_pkg::CFG_FONT_HEIGHT, 8);
        add_cfg(CFG_UNUSED, 11'h7FF);
        add_row(8'hFF, 8, 15, 1020, 1000);
        add_typed(8'h80, 1, 0, 0, 0, 0, 1);
    endfunction

    always @(negedge clk)
        pixel_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                             $time, pixel_x, pixel_y, last_pixel);
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (pixel_x !== want.x || pixel_y !== want.y || last_pixel !== want.last)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: expected %0d %0d %0b, actual %0d %0d %0b",
                                 $time, want.x, want.y, want.last,
                                 pixel_x, pixel_y, last_pixel);
                end
            end
        end
    end

    initial
    begin
        bit items_open;
        bit cfg_open;
        items_open = 1'b0;
        cfg_open = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        build_directed();
        send_idle_pct = 14;
        recv_idle_pct = 75;
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ENT_CFG)
            begin
                if (items_open)
                begin
                    stop_items();
                    drain();
                    items_open = 1'b0;
                end
                write_reg(directed_rows[k].idx, directed_rows[k].data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    close_cfg();
                    cfg_open = 1'b0;
                end
                send_row(directed_rows[k].bits, directed_rows[k].width,
                         directed_rows[k].rnum, directed_rows[k].ox, directed_rows[k].oy,
                         directed_rows[k].typed, directed_rows[k].ex, directed_rows[k].ey);
                items_open = 1'b1;
            end
        end
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 14 : ((ph == 1) ? 75 : 0);
            recv_idle_pct = (ph == 0) ? 75 : ((ph == 1) ? 14 : 0);
            for (int c = 0; c < 4; c++)
            begin
                stop_items();
                drain();
                random_config();
                repeat (24) send_random_row();
            end
        end
        stop_items();
        drain();
        $display("covered %0d glyph rows and compared %0d pixels", rows_sent, pixels_checked);
        $display("over scales 0 to 3, odd font heights, clipping on and off, three idle mixes");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

/* glyph_row_pixel_expander_core.f */
sv/glpx_pkg.sv
sv/glpx_datapath.sv
sv/glpx_ctrl.sv
sv/glyph_row_pixel_expander_core.sv
bench/testbench.sv
